// File: rtl/clfd_pkg.sv
`timescale 1ns / 1ps

package clfd_pkg;

  // Line limit and widths.
  localparam int unsigned LINE_BYTES = 512;
  localparam int unsigned FILL_W     = 10;
  localparam logic [FILL_W-1:0] LINE_LIMIT = FILL_W'(LINE_BYTES);

  // Line terminator characters.
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  // Parser modes.
  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_SKIP = 2'd1;
  localparam logic [1:0] MODE_DROP = 2'd2;

  // One received byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_t;

  // One line byte or appended terminator.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_end;
    logic       overflowed;
  } out_t;

  // The results that one byte causes, in order.
  typedef struct packed {
    logic first_valid;
    logic second_valid;
    out_t first;
    out_t second;
  } res_t;

endpackage

// File: rtl/clfd_parse.sv
`timescale 1ns / 1ps

module clfd_parse (
  input  clfd_pkg::in_t               item,
  input  logic [clfd_pkg::FILL_W-1:0] line_fill,
  input  logic [1:0]                  parse_mode,
  output logic [clfd_pkg::FILL_W-1:0] line_fill_next,
  output logic [1:0]                  parse_mode_next,
  output clfd_pkg::res_t              res
);

  logic is_crlf;
  logic do_copy;

  assign is_crlf = (item.data_byte == clfd_pkg::CHAR_CR) ||
                   (item.data_byte == clfd_pkg::CHAR_LF);

  // Decide whether this byte is handled as part of a line.
  always_comb begin
    do_copy = 1'b0;
    unique case (parse_mode)
      clfd_pkg::MODE_SKIP: do_copy = !is_crlf;
      clfd_pkg::MODE_DROP: do_copy = 1'b0;
      default:             do_copy = 1'b1;
    endcase
  end

  // Copy step, mode changes and the chunk end reset of the mode.
  always_comb begin
    line_fill_next  = line_fill;
    parse_mode_next = parse_mode;
    res             = '0;
    if (do_copy) begin
      if (line_fill >= clfd_pkg::LINE_LIMIT) begin
        res.first_valid  = 1'b1;
        res.second_valid = 1'b1;
        res.first        = '{out_byte: clfd_pkg::CHAR_CR, line_end: 1'b0, overflowed: 1'b1};
        res.second       = '{out_byte: clfd_pkg::CHAR_LF, line_end: 1'b1, overflowed: 1'b1};
        line_fill_next   = '0;
        parse_mode_next  = is_crlf ? clfd_pkg::MODE_SKIP : clfd_pkg::MODE_DROP;
      end else if (is_crlf) begin
        res.first_valid  = 1'b1;
        res.second_valid = 1'b1;
        res.first        = '{out_byte: clfd_pkg::CHAR_CR, line_end: 1'b0, overflowed: 1'b0};
        res.second       = '{out_byte: clfd_pkg::CHAR_LF, line_end: 1'b1, overflowed: 1'b0};
        line_fill_next   = '0;
        parse_mode_next  = clfd_pkg::MODE_SKIP;
      end else begin
        res.first_valid  = 1'b1;
        res.first        = '{out_byte: item.data_byte, line_end: 1'b0, overflowed: 1'b0};
        line_fill_next   = line_fill + 1'b1;
        parse_mode_next  = clfd_pkg::MODE_COPY;
      end
    end else if (parse_mode == clfd_pkg::MODE_DROP && is_crlf) begin
      parse_mode_next = clfd_pkg::MODE_SKIP;
    end
    if (item.chunk_end) begin
      parse_mode_next = clfd_pkg::MODE_COPY;
    end
  end

endmodule

// File: rtl/crlf_line_deframer_unit.sv
`timescale 1ns / 1ps

// Splits a received byte stream into CR LF terminated lines. Bytes enter one per
// cycle, unless in_stall holds them, into an input register, are parsed in a
// single pass and leave through a result register. A byte that closes a line
// yields two items (CR, then LF) that share the one result register, so it holds
// the input until the LF has moved into the result register. Lines that reach
// LINE_BYTES data bytes are closed with the overflowed flag and the rest dropped.
module crlf_line_deframer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  clfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output clfd_pkg::out_t out_data
);

  logic                        in_q_valid;
  clfd_pkg::in_t               in_q;
  logic [clfd_pkg::FILL_W-1:0] line_fill;
  logic [clfd_pkg::FILL_W-1:0] line_fill_next;
  logic [1:0]                  parse_mode;
  logic [1:0]                  parse_mode_next;
  clfd_pkg::res_t              res;
  logic                        hold_valid;
  clfd_pkg::out_t              hold_item;
  logic                        pop;
  logic                        advance;

  clfd_parse u_parse (
    .item            (in_q),
    .line_fill       (line_fill),
    .parse_mode      (parse_mode),
    .line_fill_next  (line_fill_next),
    .parse_mode_next (parse_mode_next),
    .res             (res)
  );

  // The parsed byte moves on when both of its results fit behind the output.
  assign pop      = out_valid && !out_stall;
  assign advance  = in_q_valid && !hold_valid && (!out_valid || pop);
  assign in_stall = in_q_valid && !advance;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
      line_fill  <= '0;
      parse_mode <= clfd_pkg::MODE_COPY;
    end else begin
      if (in_valid && !in_stall) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        line_fill  <= line_fill_next;
        parse_mode <= parse_mode_next;
      end
      if (hold_valid && pop) begin
        hold_valid <= 1'b0;
      end else if (advance) begin
        out_valid  <= res.first_valid;
        hold_valid <= res.second_valid;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
    if (hold_valid && pop) begin
      out_data <= hold_item;
    end else if (advance) begin
      out_data  <= res.first;
      hold_item <= res.second;
    end
  end

  // A waiting second item always sits behind a shown first one.
  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("second item held without a first item");

  // The held item is always the closing LF.
  a_hold_is_lf: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (hold_item.line_end && hold_item.out_byte == clfd_pkg::CHAR_LF))
    else $error("held item is not a closing LF");

  // The line fill never runs past the limit.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    line_fill <= clfd_pkg::LINE_LIMIT)
    else $error("line fill beyond limit");

  // The parser never rests in the unused mode.
  a_mode_used: assert property (@(posedge clk) disable iff (rst)
    parse_mode != 2'd3)
    else $error("parser in unused mode");

endmodule
